>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, off while reset is active.
`define SDM_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion sampled on the rising clock edge, active during reset too.
`define SDM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/sdm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sdm_pkg
// Shared types and constants of the stream delimiter matcher.
// ---------------------------------------------------------------------------
package sdm_pkg;

  localparam int MAX_PATTERN_DEF = 8;

  localparam int PAT_BYTES_W = 64;
  localparam int PAT_LEN_W   = 4;
  localparam int PREFIX_W    = 4;
  localparam int COUNT_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 64;

  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd1;

  // Input command codes carried on tuser.
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_DONE = 1'b1;

  // Control handed from the top level to every cell.
  typedef struct packed {
    logic load;   // a data word was accepted
    logic clear;  // end of source or full match: restart the search
  } cell_ctrl_t;

  typedef struct packed {
    logic                found;
    logic                ended_without_match;
    logic [PREFIX_W-1:0] matched_prefix;
    logic [COUNT_W-1:0]  consumed_count;
  } result_t;

endpackage : sdm_pkg
`default_nettype wire

>>> hdl/sdm_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sdm_cell
// One pattern position: holds its partial-match bit and extends the match
// of its left neighbor when the incoming byte equals its pattern byte.
// ---------------------------------------------------------------------------
module sdm_cell
  import sdm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_ctrl_t ctrl,
  input  wire logic [7:0] data_byte,
  input  wire logic [7:0] pat_byte,
  input  wire logic       pos_en,
  input  wire logic       prev_bit,
  output logic            match_bit,
  output logic            next_bit
);

  logic match_r;
  logic match_nxt;

  assign next_bit = prev_bit & pos_en & (data_byte == pat_byte);

  always_comb begin
    match_nxt = match_r;
    if (ctrl.clear) begin
      match_nxt = 1'b0;
    end else if (ctrl.load) begin
      match_nxt = next_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign match_bit = match_r;

endmodule : sdm_cell
`default_nettype wire

>>> hdl/stream_delimiter_matcher_top.sv
`default_nettype none
// The result word of an accepted input word is registered in the output stage, or in the skid register on a stall.
// Throughput: one word per cycle while the skid register is empty; the cell row updates all pattern positions at once.
// A skid register holds a result word while the output is stalled; in_tready is low only while it is full.
// Reset (synchronous, rst_n low) clears the match bits, the byte count, the valid bits of
// both output stages, and sets the pattern to all zeros with length one.
// ---------------------------------------------------------------------------
// stream_delimiter_matcher_top
// Scans a byte stream for a configured delimiter of up to MAX_PATTERN bytes
// with a row of shift-and cells and reports one result word per input word.
// ---------------------------------------------------------------------------
module stream_delimiter_matcher_top
  import sdm_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  // input stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,   // [0] cmd
  // result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [3:0] matched_prefix, [19:4] consumed_count
  output logic [OUT_TUSER_W-1:0]      out_tuser   // [0] found, [1] ended_without_match
);

  localparam logic [PAT_LEN_W-1:0] MaxLen = PAT_LEN_W'(MAX_PATTERN);

  logic [PAT_BYTES_W-1:0] pat_bytes_r;
  logic [PAT_LEN_W-1:0]   pat_len_r;
  logic [COUNT_W-1:0]     byte_cnt_r, byte_cnt_nxt;

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;

  logic [PAT_LEN_W-1:0]   eff_len;
  logic [MAX_PATTERN-1:0] pos_en;
  logic [MAX_PATTERN-1:0] match_bits;
  logic [MAX_PATTERN-1:0] next_bits;
  logic                   accept;
  logic                   cmd;
  logic                   hit;
  logic [PREFIX_W-1:0]    prefix;
  logic [COUNT_W-1:0]     count_inc;
  cell_ctrl_t             ctrl;
  result_t                res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_bytes_r <= '0;
      pat_len_r   <= PAT_LEN_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PATTERN_BYTES:  pat_bytes_r <= cfg_wdata;
        CFG_PATTERN_LENGTH: pat_len_r   <= cfg_wdata[PAT_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pat_len_r == '0) begin
      eff_len = PAT_LEN_W'(1);
    end else if (pat_len_r > MaxLen) begin
      eff_len = MaxLen;
    end else begin
      eff_len = pat_len_r;
    end
  end

  assign in_tready  = ~skid_valid_r;
  assign accept     = in_tvalid & in_tready;
  assign cmd        = in_tuser[0];
  assign ctrl.load  = accept & (cmd == CMD_DATA);
  assign ctrl.clear = accept & ((cmd == CMD_DONE) | hit);

  // Row of cells; each cell reads the registered bit of its left neighbor.
  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    assign pos_en[g] = PAT_LEN_W'(g) < eff_len;
    sdm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .data_byte (in_tdata[7:0]),
      .pat_byte  (pat_bytes_r[8*g +: 8]),
      .pos_en    (pos_en[g]),
      .prev_bit  ((g == 0) ? 1'b1 : match_bits[(g == 0) ? 0 : g-1]),
      .match_bit (match_bits[g]),
      .next_bit  (next_bits[g])
    );
  end

  always_comb begin
    hit    = 1'b0;
    prefix = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (next_bits[i]) begin
        prefix = PREFIX_W'(i + 1);
        if (PAT_LEN_W'(i + 1) == eff_len) begin
          hit = 1'b1;
        end
      end
    end
  end

  assign count_inc = (byte_cnt_r == '1) ? byte_cnt_r : byte_cnt_r + COUNT_W'(1);

  always_comb begin
    if (cmd == CMD_DONE) begin
      res.found               = 1'b0;
      res.ended_without_match = 1'b1;
      res.matched_prefix      = '0;
      res.consumed_count      = byte_cnt_r;
    end else begin
      res.found               = hit;
      res.ended_without_match = 1'b0;
      res.matched_prefix      = prefix;
      res.consumed_count      = count_inc;
    end
  end

  always_comb begin
    byte_cnt_nxt = byte_cnt_r;
    if (ctrl.clear) begin
      byte_cnt_nxt = '0;
    end else if (ctrl.load) begin
      byte_cnt_nxt = count_inc;
    end
  end

  // Output register with a skid stage behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = accept;
        out_nxt       = res;
      end
    end else if (accept) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      byte_cnt_r   <= byte_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_r.consumed_count, out_r.matched_prefix};
  assign out_tuser  = {out_r.ended_without_match, out_r.found};

endmodule : stream_delimiter_matcher_top
`default_nettype wire

>>> hdl/sdm_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sdm_checker
// Port-level checks of the stream delimiter matcher, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sdm_checker
  import sdm_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [OUT_TUSER_W-1:0] out_tuser
);

  // A result word that is not taken must stay put.
  `SDM_ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result word changed")

  // A word reports either a match or the end of the source, never both.
  `SDM_ASSERT_CLK(a_flags_excl, clk, rst_n, out_tvalid |-> !(out_tuser[0] && out_tuser[1]), "found and ended_without_match both set")

  // An end-of-source word carries no matched prefix.
  `SDM_ASSERT_CLK(a_end_prefix, clk, rst_n, out_tvalid && out_tuser[1] |-> out_tdata[3:0] == 4'd0, "end word with nonzero prefix")

  // A match has consumed at least one byte and matched at least one character.
  `SDM_ASSERT_CLK(a_found_nonzero, clk, rst_n, out_tvalid && out_tuser[0] |-> out_tdata[3:0] != 4'd0 && out_tdata[19:4] != 16'd0, "match word with zero prefix or count")

endmodule : sdm_checker

bind stream_delimiter_matcher_top sdm_checker u_sdm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
